// ===== sv/drdb_pkg.sv =====
// Shared types and constants for the dead-block RRIP replacement block.
`default_nettype none
package drdb_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SWEEP,
        ST_READ,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic cnt_clr;
        logic clear_wr;
        logic sweep_step;
        logic fill_inc;
        logic rd;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic clear_done;
        logic sweep_done;
        logic is_update;
        logic need_sweep;
        logic out_free;
    } t_sts;

    localparam logic       REG_BIP    = 1'b0;
    localparam logic       REG_DECAY  = 1'b1;
    localparam logic       OP_QUERY   = 1'b0;
    localparam logic       OP_UPDATE  = 1'b1;
    localparam logic       KIND_VICT  = 1'b0;
    localparam logic       KIND_ACK   = 1'b1;
    localparam logic [1:0] ROLE_FOLL  = 2'd0;
    localparam logic [1:0] ROLE_LIP   = 2'd1;
    localparam logic [1:0] ROLE_BIP   = 2'd2;
    localparam logic [1:0] RRPV_MAX   = 2'd3;
    localparam logic [1:0] DEAD_MAX   = 2'd3;
    localparam int         LEAD_A_MUL = 37;
    localparam int         LEAD_B_MUL = 71;
    localparam int         LEAD_B_OFF = 13;
    localparam logic [3:0] BIP_RST    = 4'd5;
    localparam logic [4:0] DECAY_RST  = 5'd13;
    localparam logic [4:0] DECAY_CAP  = 5'd16;
    localparam int         FILL_W     = 16;
    localparam int         LINE_W     = 5;

endpackage
`default_nettype wire

// ===== sv/drdb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module drdb_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/drdb_ctrl.sv =====
// Sequencer for clearing, operand reduction, decay sweep and set read-modify-write.
`default_nettype none
module drdb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire drdb_pkg::t_sts i_sts,
    output drdb_pkg::t_cmd     o_cmd
);
    drdb_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drdb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            drdb_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_done) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = drdb_pkg::ST_IDLE;
                end
            end
            drdb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = drdb_pkg::ST_MOD;
                end
            end
            drdb_pkg::ST_MOD: begin
                if (!i_sts.mod_done) begin
                    o_cmd.mod_step = 1'b1;
                end else if (i_sts.is_update) begin
                    o_cmd.fill_inc = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state = i_sts.need_sweep ? drdb_pkg::ST_SWEEP : drdb_pkg::ST_READ;
                end else begin
                    n_state = drdb_pkg::ST_READ;
                end
            end
            drdb_pkg::ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_done) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = drdb_pkg::ST_READ;
                end
            end
            drdb_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = drdb_pkg::ST_APPLY;
            end
            drdb_pkg::ST_APPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = drdb_pkg::ST_IDLE;
                end
            end
            default: n_state = drdb_pkg::ST_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/drdb_dp.sv =====
// Datapath: request registers, set row RAM, victim search, insertion and dueling.
`default_nettype none
module drdb_dp #(
    parameter int SETS     = 2048,
    parameter int WAYS     = 16,
    parameter int LEADERS  = 32,
    parameter int SEL_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire drdb_pkg::t_cmd i_cmd,
    output drdb_pkg::t_sts     o_sts,
    input  wire logic          i_op,
    input  wire logic [10:0]   i_set,
    input  wire logic [3:0]    i_way,
    input  wire logic          i_hit,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_sel,
    input  wire logic [31:0]   i_cfg_wdata,
    output logic      [31:0]   o_cfg_rdata,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_out_kind,
    output logic      [3:0]    o_out_way
);
    localparam int SET_W = $clog2(SETS);
    localparam int CNT_W = $clog2(SETS + 1);
    localparam int WAY_W = $clog2(WAYS);
    localparam int ROW_W = WAYS * drdb_pkg::LINE_W;
    localparam logic [SEL_BITS-1:0] SEL_MAX = {SEL_BITS{1'b1}};
    localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(((1 << SEL_BITS) - 1) / 2);

    logic                r_op, r_hit;
    logic [10:0]         r_set;
    logic [3:0]          r_way;
    logic [CNT_W-1:0]    r_cnt;
    logic [drdb_pkg::FILL_W-1:0] r_fill;
    logic [SEL_BITS-1:0] r_sel;
    logic [3:0]          r_bip;
    logic [4:0]          r_decay;
    logic                r_out_valid, r_out_kind;
    logic [3:0]          r_out_way;

    logic set_big, way_big;
    logic [SET_W-1:0] set_addr;
    logic [WAY_W-1:0] way_sel;
    logic [ROW_W-1:0] rdata, init_row, decay_row, apply_row, ram_wdata;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic ram_we, ram_re;
    logic [drdb_pkg::FILL_W-1:0] dmask, bmask, fill_nx;
    logic [4:0] dlog;

    assign set_big  = ({6'b0, r_set} >= 17'(SETS));
    assign way_big  = ({2'b0, r_way} >= 6'(WAYS));
    assign set_addr = SET_W'(r_set);
    assign way_sel  = WAY_W'(r_way);
    assign dlog     = (r_decay > drdb_pkg::DECAY_CAP) ? drdb_pkg::DECAY_CAP : r_decay;
    assign fill_nx  = r_fill + 1'b1;

    always_comb begin
        for (int b = 0; b < drdb_pkg::FILL_W; b++) begin
            dmask[b] = (5'(b) < dlog);
            bmask[b] = (5'(b) < {1'b0, r_bip});
        end
    end

    // leader roles: first matching event in order a0, b0, a1, b1, ...
    logic [LEADERS-1:0] hit_a, hit_b;
    for (genvar g = 0; g < LEADERS; g++) begin : g_lead
        localparam int A = (g * drdb_pkg::LEAD_A_MUL) % SETS;
        localparam int B = (g * drdb_pkg::LEAD_B_MUL + drdb_pkg::LEAD_B_OFF) % SETS;
        assign hit_a[g] = (set_addr == SET_W'(A));
        assign hit_b[g] = (set_addr == SET_W'(B));
    end

    logic [1:0] role;
    always_comb begin
        role = drdb_pkg::ROLE_FOLL;
        for (int i = LEADERS - 1; i >= 0; i--) begin
            if (hit_b[i]) role = drdb_pkg::ROLE_BIP;
            if (hit_a[i]) role = drdb_pkg::ROLE_LIP;
        end
    end

    // row layout per way: {valid, dead[1:0], rrpv[1:0]}
    logic [1:0] rrpv [WAYS];
    logic [1:0] dead [WAYS];
    logic       vld  [WAYS];
    logic       found, any3, any2, any1;
    logic [WAY_W-1:0] first_free, first_max;
    logic [1:0] maxr, ins, age;
    logic       use_bip;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            rrpv[w] = rdata[w*drdb_pkg::LINE_W +: 2];
            dead[w] = rdata[w*drdb_pkg::LINE_W+2 +: 2];
            vld[w]  = rdata[w*drdb_pkg::LINE_W+4];
        end
        any3 = 1'b0; any2 = 1'b0; any1 = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            any3 = any3 | (rrpv[w] == 2'd3);
            any2 = any2 | (rrpv[w] == 2'd2);
            any1 = any1 | (rrpv[w] == 2'd1);
        end
        maxr = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
        age  = drdb_pkg::RRPV_MAX - maxr;
        found = 1'b0;
        first_free = '0;
        first_max  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld[w] && dead[w] == 2'd0) begin
                found = 1'b1;
                first_free = WAY_W'(w);
            end
            if (rrpv[w] == maxr) first_max = WAY_W'(w);
        end
        use_bip = (role == drdb_pkg::ROLE_BIP) ||
                  (role != drdb_pkg::ROLE_LIP && r_sel < SEL_MID);
        ins = (use_bip && (r_fill & bmask) == '0) ? 2'd0 : drdb_pkg::RRPV_MAX;
        for (int w = 0; w < WAYS; w++) begin
            init_row[w*drdb_pkg::LINE_W +: drdb_pkg::LINE_W] = {1'b0, 2'd0, drdb_pkg::RRPV_MAX};
            decay_row[w*drdb_pkg::LINE_W +: drdb_pkg::LINE_W] =
                {vld[w], (dead[w] == 2'd0) ? 2'd0 : dead[w] - 2'd1, rrpv[w]};
            apply_row[w*drdb_pkg::LINE_W +: drdb_pkg::LINE_W] = {vld[w], dead[w], rrpv[w]};
            if (r_op == drdb_pkg::OP_QUERY) begin
                if (!found) apply_row[w*drdb_pkg::LINE_W +: 2] = rrpv[w] + age;
            end else if (WAY_W'(w) == way_sel) begin
                if (r_hit) begin
                    apply_row[w*drdb_pkg::LINE_W +: drdb_pkg::LINE_W] =
                        {1'b1, (dead[w] == drdb_pkg::DEAD_MAX) ? dead[w] : dead[w] + 2'd1, 2'd0};
                end else begin
                    apply_row[w*drdb_pkg::LINE_W +: drdb_pkg::LINE_W] = {1'b1, 2'd0, ins};
                end
            end
        end
    end

    always_comb begin
        ram_re    = i_cmd.rd | (i_cmd.sweep_step & (r_cnt < CNT_W'(SETS)));
        ram_raddr = i_cmd.rd ? set_addr : SET_W'(r_cnt);
        ram_we    = 1'b0;
        ram_waddr = SET_W'(r_cnt);
        ram_wdata = init_row;
        if (i_cmd.clear_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.sweep_step) begin
            ram_we    = (r_cnt != '0);
            ram_waddr = SET_W'(r_cnt - 1'b1);
            ram_wdata = decay_row;
        end else if (i_cmd.apply) begin
            ram_we    = 1'b1;
            ram_waddr = set_addr;
            ram_wdata = apply_row;
        end
    end

    drdb_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_set <= i_set;
            r_way <= i_way;
            r_hit <= i_hit;
        end else if (i_cmd.mod_step) begin
            if (set_big) r_set <= r_set - 11'(SETS);
            if (way_big) r_way <= r_way - 4'(WAYS);
        end
        if (i_cmd.apply) begin
            r_out_kind <= (r_op == drdb_pkg::OP_UPDATE) ? drdb_pkg::KIND_ACK
                                                        : drdb_pkg::KIND_VICT;
            r_out_way  <= (r_op == drdb_pkg::OP_UPDATE) ? 4'd0
                        : found ? 4'(first_free) : 4'(first_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_fill      <= '0;
            r_sel       <= SEL_MID;
            r_bip       <= drdb_pkg::BIP_RST;
            r_decay     <= drdb_pkg::DECAY_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.clear_wr | i_cmd.sweep_step) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.fill_inc) r_fill <= fill_nx;
            if (i_cfg_we) begin
                unique case (i_cfg_sel)
                    drdb_pkg::REG_BIP:   r_bip   <= i_cfg_wdata[3:0];
                    drdb_pkg::REG_DECAY: r_decay <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply && r_op == drdb_pkg::OP_UPDATE && !r_hit) begin
                if (role == drdb_pkg::ROLE_LIP && r_sel != SEL_MAX) r_sel <= r_sel + 1'b1;
                else if (role == drdb_pkg::ROLE_BIP && r_sel != '0) r_sel <= r_sel - 1'b1;
            end
            if (i_cmd.apply) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cfg_rdata = (i_cfg_sel == drdb_pkg::REG_DECAY) ? {27'd0, r_decay} : {28'd0, r_bip};
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_way   = r_out_way;

    assign o_sts.mod_done   = !set_big && !way_big;
    assign o_sts.clear_done = (r_cnt == CNT_W'(SETS - 1));
    assign o_sts.sweep_done = (r_cnt == CNT_W'(SETS));
    assign o_sts.is_update  = (r_op == drdb_pkg::OP_UPDATE);
    assign o_sts.need_sweep = ((fill_nx & dmask) == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
endmodule
`default_nettype wire

// ===== sv/dip_rrip_dead_block_replacement_top.sv =====
// Top level of the dead-block aware RRIP replacement state with LIP/BIP set dueling.
// Each request passes accept, operand reduction, row read and row write, in that order;
// the reduction subtracts SETS from the set and WAYS from the way per step until both are in range.
// A decaying update adds a sweep over the row RAM, one row a cycle, before the row read.
// After reset a clearing pass writes every row; no request is taken then.
// Requests are handled one at a time, bounded by the single read-modify-write of the row RAM.
`default_nettype none
module dip_rrip_dead_block_replacement_top #(
    parameter int SETS     = 2048,
    parameter int WAYS     = 16,
    parameter int LEADERS  = 32,
    parameter int SEL_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // set_index[10:0], way_index[14:11], is_hit[15]
    input  wire logic        i_s_axis_tuser,  // op[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [7:0]  o_m_axis_tdata,  // victim_way[3:0], zero pad[7:4]
    output logic             o_m_axis_tuser,  // reply_kind[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    drdb_pkg::t_cmd cmd;
    drdb_pkg::t_sts sts;
    logic [3:0] out_way;

    assign pready = 1'b1;

    drdb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    drdb_dp #(
        .SETS(SETS), .WAYS(WAYS), .LEADERS(LEADERS), .SEL_BITS(SEL_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (i_s_axis_tuser),
        .i_set      (i_s_axis_tdata[10:0]),
        .i_way      (i_s_axis_tdata[14:11]),
        .i_hit      (i_s_axis_tdata[15]),
        .i_cfg_we   (psel & penable & pwrite),
        .i_cfg_sel  (paddr[2]),
        .i_cfg_wdata(pwdata),
        .o_cfg_rdata(prdata),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_out_kind (o_m_axis_tuser),
        .o_out_way  (out_way)
    );

    assign o_m_axis_tdata = {4'd0, out_way};
endmodule
`default_nettype wire
